// File: hw/rtl/irpfd_pkg.sv
// ----------------------------------------------------------------------------
// irpfd_pkg
// Shared types, register indexes and the duration match function of the
// infrared pulse frame decoder.
// ----------------------------------------------------------------------------
package irpfd_pkg;

  localparam int DUR_W       = 16;
  localparam int CODE_W      = 32;
  localparam int CNT_W       = 6;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int FRAME_BITS_DEF = 32;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_LEADER_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEADER_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MARK_HIGH   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE   = 3'd5;

  localparam logic [DUR_W-1:0] LEADER_LOW_RST  = 16'd9000;
  localparam logic [DUR_W-1:0] LEADER_HIGH_RST = 16'd4500;
  localparam logic [DUR_W-1:0] ZERO_LOW_RST    = 16'd560;
  localparam logic [DUR_W-1:0] ONE_LOW_RST     = 16'd1690;
  localparam logic [DUR_W-1:0] MARK_HIGH_RST   = 16'd560;
  localparam logic [DUR_W-1:0] TOLERANCE_RST   = 16'd200;

  typedef struct packed {
    logic             func;
    logic [DUR_W-1:0] duration;
  } in_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              code_valid;
    logic              frame_done;
  } out_t;

  // pulse after classification: level plus the targets it hit
  typedef struct packed {
    logic level;
    logic lead_hit;   // leader low or leader high, by level
    logic short_hit;  // zero low or mark high, by level
    logic one_hit;    // one low, meaningful for low pulses only
  } pulse_class_t;

  // duration strictly inside target +/- tol; never when tol exceeds target
  function automatic logic near_target(logic [DUR_W-1:0] d, logic [DUR_W-1:0] t,
                                       logic [DUR_W-1:0] tol);
    logic [DUR_W:0] hi;
    logic [DUR_W-1:0] lo;
    hi = {1'b0, t} + {1'b0, tol};
    lo = t - tol;
    if (tol > t) begin
      return 1'b0;
    end
    return (d > lo) && ({1'b0, d} < hi);
  endfunction

endpackage

// File: hw/rtl/irpfd_front.sv
// ----------------------------------------------------------------------------
// irpfd_front
// Holds the timing registers and classifies each incoming pulse word
// against the targets for its level.
// ----------------------------------------------------------------------------
module irpfd_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [irpfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [irpfd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  irpfd_pkg::in_t                   pulse,
  output irpfd_pkg::pulse_class_t          pulse_class
);
  import irpfd_pkg::*;

  logic [DUR_W-1:0] leader_low;
  logic [DUR_W-1:0] leader_high;
  logic [DUR_W-1:0] zero_low;
  logic [DUR_W-1:0] one_low;
  logic [DUR_W-1:0] mark_high;
  logic [DUR_W-1:0] tolerance;

  logic [DUR_W-1:0] lead_target;
  logic [DUR_W-1:0] short_target;

  always_ff @(posedge clk) begin
    if (rst) begin
      leader_low  <= LEADER_LOW_RST;
      leader_high <= LEADER_HIGH_RST;
      zero_low    <= ZERO_LOW_RST;
      one_low     <= ONE_LOW_RST;
      mark_high   <= MARK_HIGH_RST;
      tolerance   <= TOLERANCE_RST;
    end else if (cfg_we) begin
      // indexes past the last register drop the write
      unique case (cfg_index)
        REG_LEADER_LOW:  leader_low  <= cfg_data;
        REG_LEADER_HIGH: leader_high <= cfg_data;
        REG_ZERO_LOW:    zero_low    <= cfg_data;
        REG_ONE_LOW:     one_low     <= cfg_data;
        REG_MARK_HIGH:   mark_high   <= cfg_data;
        REG_TOLERANCE:   tolerance   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign lead_target  = pulse.func ? leader_high : leader_low;
  assign short_target = pulse.func ? mark_high : zero_low;

  always_comb begin
    pulse_class.level     = pulse.func;
    pulse_class.lead_hit  = near_target(pulse.duration, lead_target, tolerance);
    pulse_class.short_hit = near_target(pulse.duration, short_target, tolerance);
    pulse_class.one_hit   = near_target(pulse.duration, one_low, tolerance);
  end

endmodule

// File: hw/rtl/irpfd_queue.sv
// ----------------------------------------------------------------------------
// irpfd_queue
// Two-entry queue of classified pulse words between front and back.
// ----------------------------------------------------------------------------
module irpfd_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  irpfd_pkg::pulse_class_t push_data,
  output logic                    full,
  input  logic                    pop,
  output logic                    not_empty,
  output irpfd_pkg::pulse_class_t pop_data
);
  import irpfd_pkg::*;

  pulse_class_t entry [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign pop_data  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// File: hw/rtl/irpfd_back.sv
// ----------------------------------------------------------------------------
// irpfd_back
// Frame state machine: takes classified pulse words, shifts in bits and
// holds each result word in an output register.
// ----------------------------------------------------------------------------
module irpfd_back #(
  parameter int FRAME_BITS = irpfd_pkg::FRAME_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    q_valid,
  input  irpfd_pkg::pulse_class_t q_data,
  output logic                    q_pop,
  output logic                    out_valid,
  input  logic                    out_ready,
  output irpfd_pkg::out_t         out_data
);
  import irpfd_pkg::*;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_START = 2'd1;
  localparam logic [1:0] PH_RECV  = 2'd2;

  localparam logic [CNT_W-1:0] FRAME_LEN = CNT_W'(FRAME_BITS);

  logic [1:0]        phase;
  logic [1:0]        phase_next;
  logic [CNT_W-1:0]  bits_received;
  logic [CNT_W-1:0]  bits_received_next;
  logic [CNT_W-1:0]  bits_inc;
  logic [CODE_W-1:0] shift_code;
  logic [CODE_W-1:0] shift_code_next;
  logic              frame_valid;
  logic              frame_valid_next;
  logic              done;

  // advance when the output register is free or being emptied
  assign q_pop    = q_valid && (!out_valid || out_ready);
  assign bits_inc = bits_received + CNT_W'(1);

  always_comb begin
    phase_next         = phase;
    bits_received_next = bits_received;
    shift_code_next    = shift_code;
    frame_valid_next   = frame_valid;
    done               = 1'b0;
    if (!q_data.level) begin
      unique case (phase)
        PH_START: begin
          if (q_data.lead_hit) begin
            bits_received_next = '0;
            frame_valid_next   = 1'b0;
            phase_next         = PH_RECV;
          end else begin
            phase_next         = PH_IDLE;
            bits_received_next = '0;
            shift_code_next    = '0;
            frame_valid_next   = 1'b0;
          end
        end
        PH_RECV: begin
          if (q_data.short_hit || q_data.one_hit) begin
            // zero wins when both targets match
            shift_code_next[bits_received[4:0]] = !q_data.short_hit;
            bits_received_next = bits_inc;
            if (bits_inc >= FRAME_LEN) begin
              phase_next       = PH_IDLE;
              frame_valid_next = 1'b1;
              done             = 1'b1;
            end
          end else begin
            phase_next         = PH_IDLE;
            bits_received_next = '0;
            shift_code_next    = '0;
            frame_valid_next   = 1'b0;
          end
        end
        default: phase_next = PH_START;
      endcase
    end else begin
      // high pulses only check timing; ignored outside start and receive
      if ((phase == PH_START && !q_data.lead_hit) ||
          (phase == PH_RECV && !q_data.short_hit)) begin
        phase_next         = PH_IDLE;
        bits_received_next = '0;
        shift_code_next    = '0;
        frame_valid_next   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      bits_received <= '0;
      shift_code    <= '0;
      frame_valid   <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (q_pop) begin
        phase         <= phase_next;
        bits_received <= bits_received_next;
        shift_code    <= shift_code_next;
        frame_valid   <= frame_valid_next;
        out_valid     <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data.code       <= shift_code_next;
      out_data.code_valid <= frame_valid_next;
      out_data.frame_done <= done;
    end
  end

endmodule

// File: hw/rtl/ir_pulse_frame_decoder_core.sv
// ----------------------------------------------------------------------------
// ir_pulse_frame_decoder_core
// Decodes infrared remote frames from measured pulse durations.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/in_data) takes one word per pulse: its
//   level (func) and its saturated length in ticks. Every pulse yields
//   exactly one result word on the output channel (out_valid/out_ready/
//   out_data): the code shifted in so far, code_valid, and frame_done set
//   for the pulse that completed a frame.
//   Timing targets and tolerance are written through cfg_we/cfg_index/
//   cfg_data while no pulse is in flight; indexes past the last register
//   are ignored.
//   The front classifies each accepted pulse into a two-entry queue, and the
//   back runs the frame state machine into the output register. Throughput
//   is one pulse per cycle while the receiver keeps taking results.
//   When the receiver stalls, the output register holds, the queue fills and
//   in_ready drops once both entries are taken.
//   Reset (rst, synchronous) restores the default timings, empties the
//   queue and returns the decoder to idle with a cleared code.
// ----------------------------------------------------------------------------
module ir_pulse_frame_decoder_core #(
  parameter int FRAME_BITS = irpfd_pkg::FRAME_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  irpfd_pkg::in_t                   in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output irpfd_pkg::out_t                  out_data,
  input  logic                             cfg_we,
  input  logic [irpfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [irpfd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import irpfd_pkg::*;

  pulse_class_t front_class;
  pulse_class_t q_data;
  logic         q_full;
  logic         q_valid;
  logic         q_pop;
  logic         push;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  irpfd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pulse      (in_data),
    .pulse_class(front_class)
  );

  irpfd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(front_class),
    .full     (q_full),
    .pop      (q_pop),
    .not_empty(q_valid),
    .pop_data (q_data)
  );

  irpfd_back #(
    .FRAME_BITS(FRAME_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Pulse-level check of the infrared frame decoder: a directed run at the
// default timings, then random frames and noise under several timing sets,
// each with four patterns of sender gaps and receiver back-pressure. Every
// result word is compared field by field with a local decoder model.
// ----------------------------------------------------------------------------
module testbench;
  import irpfd_pkg::*;

  localparam logic LEVEL_LOW  = 1'b0;
  localparam logic LEVEL_HIGH = 1'b1;

  // indexes past the last register; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  localparam logic [DUR_W-1:0] DUR_TOP    = '1;
  localparam int               HANG_LIMIT = 4000;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_START = 2'd1,
    PH_RECV  = 2'd2
  } dec_phase_e;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  typedef struct packed {
    logic [DUR_W-1:0] leader_low;
    logic [DUR_W-1:0] leader_high;
    logic [DUR_W-1:0] zero_low;
    logic [DUR_W-1:0] one_low;
    logic [DUR_W-1:0] mark_high;
    logic [DUR_W-1:0] tolerance;
  } timing_set_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // decoder model state and its copy of the timing registers
  timing_set_t       timing;
  dec_phase_e        dec_phase;
  logic [CNT_W-1:0]  bits_held;
  logic [CODE_W-1:0] code_sr;
  logic              frame_held;

  in_t  pulse_queue[$];
  out_t frame_results[$];
  idle_mode_e idle_mode = IDLE_NONE;

  int pulses_queued = 0;
  int pulses_taken  = 0;
  int words_checked = 0;
  int frames_seen   = 0;
  int settings_run  = 0;
  int fail_count    = 0;
  int hang_cycles   = 0;

  ir_pulse_frame_decoder_core dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- model
  function automatic bit within_window(input logic [DUR_W-1:0] d,
                                       input logic [DUR_W-1:0] t);
    if (timing.tolerance > t) return 1'b0;
    return int'(d) > int'(t) - int'(timing.tolerance) &&
           int'(d) < int'(t) + int'(timing.tolerance);
  endfunction

  function automatic void clear_decoder();
    dec_phase  = PH_IDLE;
    bits_held  = '0;
    code_sr    = '0;
    frame_held = 1'b0;
  endfunction

  function automatic out_t decode_pulse(input in_t p);
    out_t r;
    bit   zero_hit;
    bit   one_hit;
    bit   done;
    done = 1'b0;
    if (p.func == LEVEL_LOW) begin
      case (dec_phase)
        PH_START: begin
          if (within_window(p.duration, timing.leader_low)) begin
            // old code bits stay until overwritten
            bits_held  = '0;
            frame_held = 1'b0;
            dec_phase  = PH_RECV;
          end else begin
            clear_decoder();
          end
        end
        PH_RECV: begin
          zero_hit = within_window(p.duration, timing.zero_low);
          one_hit  = !zero_hit && within_window(p.duration, timing.one_low);
          if (zero_hit || one_hit) begin
            code_sr[bits_held[4:0]] = one_hit;
            bits_held = bits_held + CNT_W'(1);
            if (bits_held >= CNT_W'(FRAME_BITS_DEF)) begin
              dec_phase  = PH_IDLE;
              frame_held = 1'b1;
              done       = 1'b1;
            end
          end else begin
            clear_decoder();
          end
        end
        default: dec_phase = PH_START;
      endcase
    end else begin
      case (dec_phase)
        PH_START: if (!within_window(p.duration, timing.leader_high)) clear_decoder();
        PH_RECV:  if (!within_window(p.duration, timing.mark_high)) clear_decoder();
        default: ;
      endcase
    end
    r.code       = code_sr;
    r.code_valid = frame_held;
    r.frame_done = done;
    return r;
  endfunction

  // ---------------------------------------------------------------- idling
  function automatic bit sender_gap();
    case (idle_mode)
      IDLE_SENDER: return $urandom_range(0, 99) < 82;
      IDLE_BOTH:   return $urandom_range(0, 99) < 11;
      default:     return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stall();
    case (idle_mode)
      IDLE_RECEIVER: return $urandom_range(0, 99) < 82;
      IDLE_BOTH:     return $urandom_range(0, 99) < 11;
      default:       return 1'b0;
    endcase
  endfunction

  // ---------------------------------------------------------------- driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        frame_results.push_back(decode_pulse(in_data));
        pulses_taken++;
      end
      if (!in_valid || in_ready) begin
        if (pulse_queue.size() != 0 && !sender_gap()) begin
          in_valid <= 1'b1;
          in_data  <= pulse_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk) begin : result_check
    out_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (frame_results.size() == 0) begin
          $error("result word with no pulse pending: code %h", out_data.code);
          fail_count++;
        end else begin
          want = frame_results.pop_front();
          words_checked++;
          if (out_data.frame_done === 1'b1) frames_seen++;
          if (out_data.code !== want.code) begin
            $error("code: expected %h, got %h", want.code, out_data.code);
            fail_count++;
          end
          if (out_data.code_valid !== want.code_valid) begin
            $error("code_valid: expected %b, got %b", want.code_valid,
                   out_data.code_valid);
            fail_count++;
          end
          if (out_data.frame_done !== want.frame_done) begin
            $error("frame_done: expected %b, got %b", want.frame_done,
                   out_data.frame_done);
            fail_count++;
          end
        end
      end
      out_ready <= !receiver_stall();
    end
  end

  // ---------------------------------------------------------------- watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      hang_cycles <= 0;
    end else if (hang_cycles >= HANG_LIMIT) begin
      $display("ir_pulse_frame_decoder_core: mismatch");
      $finish;
    end else begin
      hang_cycles <= hang_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- stimulus
  task automatic queue_pulse(input logic lvl, input logic [DUR_W-1:0] d);
    in_t p;
    p.func     = lvl;
    p.duration = d;
    pulse_queue.push_back(p);
    pulses_queued++;
  endtask

  // duration strictly inside the window, or anything if the window is empty
  function automatic logic [DUR_W-1:0] pick_near(input logic [DUR_W-1:0] t);
    int lo;
    int hi;
    lo = int'(t) - int'(timing.tolerance) + 1;
    hi = int'(t) + int'(timing.tolerance) - 1;
    if (hi > int'(DUR_TOP)) hi = int'(DUR_TOP);
    if (timing.tolerance > t || lo > hi) return DUR_W'($urandom_range(0, int'(DUR_TOP)));
    return DUR_W'($urandom_range(hi, lo));
  endfunction

  // duration right on a window edge, which must not match
  function automatic logic [DUR_W-1:0] pick_edge(input logic [DUR_W-1:0] t);
    if (timing.tolerance > t) return DUR_W'($urandom_range(0, int'(DUR_TOP)));
    if ($urandom_range(0, 1) == 0 || int'(t) + int'(timing.tolerance) > int'(DUR_TOP))
      return t - timing.tolerance;
    return t + timing.tolerance;
  endfunction

  task automatic queue_noise(input int count);
    repeat (count) begin
      case ($urandom_range(0, 3))
        0: queue_pulse(LEVEL_LOW, pick_edge($urandom_range(0, 1) ? timing.zero_low
                                                                  : timing.one_low));
        1: queue_pulse(LEVEL_HIGH, pick_edge($urandom_range(0, 1) ? timing.mark_high
                                                                  : timing.leader_high));
        default: queue_pulse(1'($urandom_range(0, 1)),
                             DUR_W'($urandom_range(0, int'(DUR_TOP))));
      endcase
    end
  endtask

  task automatic queue_frame();
    bit one_bit;
    queue_pulse(LEVEL_LOW, DUR_W'($urandom_range(0, int'(DUR_TOP))));
    if ($urandom_range(0, 3) != 0) queue_pulse(LEVEL_HIGH, pick_near(timing.leader_high));
    queue_pulse(LEVEL_LOW, pick_near(timing.leader_low));
    repeat (FRAME_BITS_DEF) begin
      if ($urandom_range(0, 4) != 0) queue_pulse(LEVEL_HIGH, pick_near(timing.mark_high));
      one_bit = 1'($urandom_range(0, 1));
      queue_pulse(LEVEL_LOW, pick_near(one_bit ? timing.one_low : timing.zero_low));
      // break the odd frame part way through
      if ($urandom_range(0, 149) == 0) queue_noise(1);
    end
  endtask

  task automatic wait_drained();
    while (pulses_taken != pulses_queued || frame_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic queue_traffic(input int count);
    int goal;
    int room;
    int burst;
    goal = pulses_queued + count;
    while (pulses_queued < goal) begin
      room = goal - pulses_queued;
      // start a frame only where it roughly fits, so the total stays near the goal
      if (room >= 56 && $urandom_range(0, 99) < 85) begin
        queue_frame();
      end else begin
        burst = $urandom_range(1, 6);
        queue_noise(burst < room ? burst : room);
      end
    end
  endtask

  // cycle through every handshake pattern under the current timings
  task automatic run_setting(input int count);
    idle_mode = idle_mode.first();
    repeat (4) begin
      queue_traffic(count / 4);
      wait_drained();
      idle_mode = idle_mode.next();
    end
    settings_run++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DUR_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_LEADER_LOW:  timing.leader_low  = val;
      REG_LEADER_HIGH: timing.leader_high = val;
      REG_ZERO_LOW:    timing.zero_low    = val;
      REG_ONE_LOW:     timing.one_low     = val;
      REG_MARK_HIGH:   timing.mark_high   = val;
      REG_TOLERANCE:   timing.tolerance   = val;
      default: ;
    endcase
  endtask

  task automatic apply_timings(input timing_set_t s);
    wait_drained();
    // let the two-stage pipe settle before touching the registers
    repeat (4) @(posedge clk);
    write_reg(REG_LEADER_LOW, s.leader_low);
    write_reg(REG_LEADER_HIGH, s.leader_high);
    write_reg(REG_ZERO_LOW, s.zero_low);
    write_reg(REG_ONE_LOW, s.one_low);
    write_reg(REG_MARK_HIGH, s.mark_high);
    write_reg(REG_TOLERANCE, s.tolerance);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    timing = '{LEADER_LOW_RST, LEADER_HIGH_RST, ZERO_LOW_RST, ONE_LOW_RST,
               MARK_HIGH_RST, TOLERANCE_RST};
    clear_decoder();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed pulses at the default timings
    queue_pulse(LEVEL_HIGH, DUR_TOP);                               // ignored in idle
    queue_pulse(LEVEL_HIGH, '0);
    queue_pulse(LEVEL_LOW, '0);                                     // wake to start
    queue_pulse(LEVEL_HIGH, LEADER_HIGH_RST);
    queue_pulse(LEVEL_LOW, LEADER_LOW_RST - TOLERANCE_RST);         // lower edge misses
    queue_pulse(LEVEL_LOW, DUR_TOP);
    queue_pulse(LEVEL_LOW, LEADER_LOW_RST - TOLERANCE_RST + 16'd1);
    queue_pulse(LEVEL_HIGH, MARK_HIGH_RST + TOLERANCE_RST);         // upper edge misses
    queue_pulse(LEVEL_LOW, 16'd12);
    queue_pulse(LEVEL_LOW, LEADER_LOW_RST + TOLERANCE_RST - 16'd1);
    queue_pulse(LEVEL_LOW, ZERO_LOW_RST - TOLERANCE_RST + 16'd1);
    queue_pulse(LEVEL_HIGH, MARK_HIGH_RST + TOLERANCE_RST - 16'd1);
    queue_pulse(LEVEL_LOW, ONE_LOW_RST + TOLERANCE_RST - 16'd1);
    queue_pulse(LEVEL_LOW, ONE_LOW_RST + TOLERANCE_RST);
    queue_pulse(LEVEL_LOW, 16'd5);
    queue_pulse(LEVEL_HIGH, LEADER_HIGH_RST - TOLERANCE_RST);
    queue_pulse(LEVEL_LOW, 16'd5);
    queue_pulse(LEVEL_LOW, LEADER_LOW_RST);
    queue_pulse(LEVEL_LOW, ONE_LOW_RST - TOLERANCE_RST + 16'd1);
    queue_pulse(LEVEL_LOW, 16'd1000);                               // between bit windows
    wait_drained();

    run_setting(300);

    // exact-match windows at both ends of the range; spare indexes dropped
    apply_timings('{16'hFFFF, 16'd1, 16'd2, 16'hFFFE, 16'd1, 16'd1});
    @(posedge clk);
    write_reg(REG_SPARE_6, '0);
    write_reg(REG_SPARE_7, DUR_TOP);
    @(posedge clk);
    cfg_we <= 1'b0;
    run_setting(240);

    // zero and one windows overlap; zero takes priority
    apply_timings('{16'd100, 16'd50, 16'd300, 16'd320, 16'd40, 16'd30});
    run_setting(240);

    // maximum tolerance: only full-scale targets can match, zero targets never
    apply_timings('{16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF});
    run_setting(160);

    // zero tolerance: nothing matches
    apply_timings('{LEADER_LOW_RST, LEADER_HIGH_RST, ZERO_LOW_RST, ONE_LOW_RST,
                    MARK_HIGH_RST, 16'd0});
    run_setting(60);

    apply_timings('{LEADER_LOW_RST, LEADER_HIGH_RST, ZERO_LOW_RST, ONE_LOW_RST,
                    MARK_HIGH_RST, TOLERANCE_RST});
    run_setting(240);

    wait_drained();
    repeat (8) @(posedge clk);
    $display("Sent %0d pulses across %0d timing sets, each under four handshake patterns;",
             pulses_taken, settings_run);
    $display("checked %0d result words, %0d of them completing a frame.",
             words_checked, frames_seen);
    if (fail_count == 0) begin
      $display("ir_pulse_frame_decoder_core: match");
    end else begin
      $display("ir_pulse_frame_decoder_core: mismatch");
    end
    $finish;
  end

endmodule
